// ----- design/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_LT  = 3'd4;
	localparam logic [2:0] OP_EQ  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_GCD,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic gcd_step;
		logic div_start;
		logic div_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ----- design/rau_ctrl.sv -----
// Sequencer for the rational arithmetic unit.
`default_nettype none
module rau_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_fire,
	input  wire rau_pkg::sts_t sts,
	output rau_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               out_valid
);
	rau_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rau_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::S_IDLE: if (in_fire) state_d = rau_pkg::S_MUL;
			rau_pkg::S_MUL:  state_d = rau_pkg::S_SUM;
			rau_pkg::S_SUM:  state_d = sts.early ? rau_pkg::S_OUT : rau_pkg::S_GCD;
			rau_pkg::S_GCD:  if (sts.gcd_done) state_d = rau_pkg::S_DIV;
			rau_pkg::S_DIV:  if (sts.div_done) state_d = rau_pkg::S_FIN;
			rau_pkg::S_FIN:  state_d = rau_pkg::S_OUT;
			rau_pkg::S_OUT:  if (out_fire) state_d = rau_pkg::S_IDLE;
			default:         state_d = rau_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rau_pkg::S_IDLE: cmd.load = in_fire;
			rau_pkg::S_MUL:  cmd.mul = 1'b1;
			rau_pkg::S_SUM:  cmd.sum = 1'b1;
			rau_pkg::S_GCD: begin
				cmd.gcd_step = !sts.gcd_done;
				cmd.div_start = sts.gcd_done;
			end
			rau_pkg::S_DIV:  cmd.div_step = 1'b1;
			rau_pkg::S_FIN:  cmd.fin = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != rau_pkg::S_IDLE);
	assign out_valid = (state_q == rau_pkg::S_OUT);
endmodule
`default_nettype wire

// ----- design/rau_dp.sv -----
// Datapath: operand split, products, sum, binary gcd, restoring division, pack.
`default_nettype none
module rau_dp #(
	parameter int WIDTH = 32
) (
	input  wire logic          clk,
	input  wire rau_pkg::cmd_t cmd,
	input  wire logic [2:0]    op,
	input  wire logic [31:0]   a_num,
	input  wire logic [31:0]   a_den,
	input  wire logic [31:0]   b_num,
	input  wire logic [31:0]   b_den,
	input  wire logic          normalize_only,
	output rau_pkg::sts_t      sts,
	output logic [31:0]        res_num,
	output logic [30:0]        res_den,
	output logic               truth,
	output logic [1:0]         status
);
	localparam int W2 = 2 * WIDTH;
	localparam int CW = $clog2(W2 + 1);

	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic             ann_q, adn_q, bnn_q, bdn_q;
	logic             aneg_q, bneg_q, norm_q;
	logic [2:0]       op_q;
	logic [W2-1:0]    p_q, q_q, d_q;
	logic             rneg_q, early_q;
	logic [W2-1:0]    x_q, y_q, rn_q, rd_q;
	logic [CW-1:0]    k_q, cnt_q;
	logic [W2-1:0]    g_q, quo_q, rem_q, dvd_q;
	logic             pass_q;
	logic [31:0]      res_num_q;
	logic [30:0]      res_den_q;
	logic             truth_q;
	logic [1:0]       status_q;

	function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
		mag = v[WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	logic [WIDTH-1:0] an_w, ad_w, bn_w, bd_w;
	assign an_w = a_num[WIDTH-1:0];
	assign ad_w = a_den[WIDTH-1:0];
	assign bn_w = b_num[WIDTH-1:0];
	assign bd_w = b_den[WIDTH-1:0];

	// sum stage
	logic [W2-1:0] s_num, s_den, sum_w;
	logic          s_neg, qn, cmp_lt, cmp_eq, s_early, bz, az;
	logic [1:0]    s_st;
	logic          s_truth;
	always_comb begin
		az = (ad_q == '0);
		bz = (bd_q == '0);
		qn = (op_q == rau_pkg::OP_SUB) ? !bneg_q : bneg_q;
		if (q_q == '0) qn = 1'b0;
		s_num = p_q;
		s_den = d_q;
		s_neg = aneg_q;
		s_early = 1'b0;
		s_st = rau_pkg::ST_OK;
		s_truth = 1'b0;
		sum_w = p_q + q_q;
		// signed compare of p (sign a) and q (sign b)
		if (aneg_q != (bneg_q && q_q != '0))
			cmp_lt = aneg_q;
		else if (aneg_q) cmp_lt = p_q > q_q;
		else cmp_lt = p_q < q_q;
		cmp_eq = (aneg_q == (bneg_q && q_q != '0)) && (p_q == q_q);
		if (az || (!norm_q && bz)) begin
			s_early = 1'b1;
			s_st = rau_pkg::ST_ZERO;
		end else if (norm_q) begin
			s_num = p_q;
			s_den = d_q;
		end else begin
			case (op_q)
				rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
					if (aneg_q == qn) s_num = sum_w;
					else if (p_q >= q_q) s_num = p_q - q_q;
					else begin
						s_num = q_q - p_q;
						s_neg = qn;
					end
				end
				rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
					s_neg = aneg_q != bneg_q;
					if (op_q == rau_pkg::OP_DIV && bn_q == '0) begin
						s_early = 1'b1;
						s_st = rau_pkg::ST_ZERO;
					end
				end
				default: begin
					s_early = 1'b1;
					s_truth = (op_q == rau_pkg::OP_LT) ? cmp_lt : cmp_eq;
				end
			endcase
		end
		if (s_num == '0) s_neg = 1'b0;
	end

	logic [W2-1:0] ysub;
	logic          gdone;
	assign gdone = (y_q == '0) || (x_q == '0);
	assign ysub = (x_q > y_q) ? x_q - y_q : y_q - x_q;

	logic [W2:0] trial;
	assign trial = {rem_q, dvd_q[W2-1]} - {1'b0, g_q};

	logic [W2-1:0] lim;
	assign lim = {{(W2-WIDTH){1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			an_q <= mag(an_w); ad_q <= mag(ad_w);
			bn_q <= mag(bn_w); bd_q <= mag(bd_w);
			ann_q <= an_w[WIDTH-1]; adn_q <= ad_w[WIDTH-1];
			bnn_q <= bn_w[WIDTH-1]; bdn_q <= bd_w[WIDTH-1];
			op_q <= op;
			norm_q <= normalize_only || (op > rau_pkg::OP_EQ);
		end
		if (cmd.mul) begin
			aneg_q <= (an_q != '0) && (ann_q != adn_q);
			bneg_q <= (bn_q != '0) && (bnn_q != bdn_q);
			if (norm_q) begin
				p_q <= {{WIDTH{1'b0}}, an_q};
				d_q <= {{WIDTH{1'b0}}, ad_q};
				q_q <= '0;
			end else if (op_q == rau_pkg::OP_MUL) begin
				p_q <= an_q * bn_q;
				d_q <= ad_q * bd_q;
				q_q <= '0;
			end else if (op_q == rau_pkg::OP_DIV) begin
				p_q <= an_q * bd_q;
				d_q <= ad_q * bn_q;
				q_q <= '0;
			end else begin
				p_q <= an_q * bd_q;
				q_q <= bn_q * ad_q;
				d_q <= ad_q * bd_q;
			end
		end
		if (cmd.sum) begin
			rn_q <= s_num;
			rd_q <= s_den;
			rneg_q <= s_neg;
			x_q <= s_num;
			y_q <= s_den;
			k_q <= '0;
			early_q <= s_early || (s_num == '0);
			res_num_q <= '0;
			res_den_q <= (s_early || s_num != '0) ? '0 : 31'd1;
			truth_q <= s_truth;
			status_q <= s_st;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1; y_q <= y_q >> 1; k_q <= k_q + 1'b1;
			end else if (!x_q[0]) x_q <= x_q >> 1;
			else if (!y_q[0]) y_q <= y_q >> 1;
			else begin
				x_q <= (x_q < y_q) ? x_q : y_q;
				y_q <= ysub;
			end
		end
		if (cmd.div_start) begin
			g_q <= (x_q | y_q) << k_q;
			dvd_q <= rn_q;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			pass_q <= 1'b0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[W2-2:0], !trial[W2]};
			if (cnt_q == CW'(W2 - 1)) begin
				cnt_q <= '0;
				pass_q <= 1'b1;
				if (!pass_q) begin
					rn_q <= {quo_q[W2-2:0], !trial[W2]};
					dvd_q <= rd_q;
					rem_q <= '0;
				end else rd_q <= {quo_q[W2-2:0], !trial[W2]};
			end else begin
				cnt_q <= cnt_q + 1'b1;
				dvd_q <= dvd_q << 1;
				if (trial[W2]) rem_q <= {rem_q[W2-2:0], dvd_q[W2-1]};
				else rem_q <= trial[W2-1:0];
			end
		end
		if (cmd.fin) begin
			if (rd_q > lim - 1'b1 || rn_q > (rneg_q ? lim : lim - 1'b1)) begin
				status_q <= rau_pkg::ST_OVF;
				res_num_q <= '0;
				res_den_q <= '0;
			end else begin
				res_num_q <= rneg_q ? (~32'(rn_q) + 32'd1) : 32'(rn_q);
				res_den_q <= 31'(rd_q);
			end
		end
	end

	assign sts.early = s_early || (s_num == '0);
	assign sts.gcd_done = gdone;
	assign sts.div_done = pass_q && (cnt_q == CW'(W2 - 1));
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign truth = truth_q;
	assign status = status_q;
endmodule
`default_nettype wire

// ----- design/rational_arithmetic_unit.sv -----
// Full path: products, sum, binary gcd loop, divide numerator then denominator, pack.
// Operations that end early (errors, compares, zero results) skip the gcd and division.
// One item at a time: the next beat is taken after the result is accepted.
// Throughput is bounded by the binary gcd loop and the bit-serial divider.
// arst_n clears the sequencer; no result is pending after reset.
`default_nettype none
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [135:0] s_tdata, // op, a_num, a_den, b_num, b_den, normalize_only
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata  // res_num, res_den, truth, status
);
	rau_pkg::cmd_t cmd;
	rau_pkg::sts_t sts;
	logic busy;
	logic [31:0] res_num;
	logic [30:0] res_den;
	logic truth;
	logic [1:0] status;

	assign s_tready = !busy;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
	);

	rau_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .cmd(cmd),
		.op(s_tdata[2:0]), .a_num(s_tdata[34:3]), .a_den(s_tdata[66:35]),
		.b_num(s_tdata[98:67]), .b_den(s_tdata[130:99]), .normalize_only(s_tdata[131]),
		.sts(sts), .res_num(res_num), .res_den(res_den), .truth(truth), .status(status)
	);

	assign m_tdata = {6'd0, status, truth, res_den, res_num};
endmodule
`default_nettype wire

// ----- design/rau_checker.sv -----
// Port-level checker for the rational arithmetic unit.
`default_nettype none
module rau_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[65:64] <= rau_pkg::ST_OVF) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65:64] != rau_pkg::ST_OK |-> m_tdata[63:0] == '0)
		else $error("error payload");
	a_in_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- test/rational_arithmetic_unit_tb.sv -----
// Self-checking testbench for the rational arithmetic unit: directed table plus random beats.
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_tb;
	localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
	localparam logic [31:0] MIN_NEG = 32'h8000_0000;
	localparam int N_RANDOM = 480;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
		logic        normalize_only;
	} frac_op_t;

	typedef struct {
		logic [31:0] res_num;
		logic [30:0] res_den;
		logic        truth;
		logic [1:0]  status;
	} frac_res_t;

	typedef struct {
		frac_op_t  stim;
		logic      typed;
		frac_res_t res;
	} table_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0; // op, a_num, a_den, b_num, b_den, normalize_only
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata; // res_num, res_den, truth, status

	frac_res_t pending_results[$];
	int        fail_count = 0;
	int        results_seen = 0;
	bit        stim_done = 1'b0;

	rational_arithmetic_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("rational_arithmetic_unit test failed");
		$finish;
	end

	function automatic logic [63:0] magnitude(logic [31:0] v);
		logic [31:0] m;
		m = v[31] ? -v : v;
		return {32'b0, m};
	endfunction

	function automatic frac_res_t reduce_frac(logic neg, logic [63:0] num, logic [63:0] den);
		frac_res_t   r;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] lim;
		r = '{res_num: '0, res_den: '0, truth: 1'b0, status: rau_pkg::ST_OK};
		lim = 64'h8000_0000;
		if (num == 0) begin
			r.res_den = 31'd1;
			return r;
		end
		x = num;
		y = den;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		num = num / x;
		den = den / x;
		if (den > lim - 1 || num > (neg ? lim : lim - 1)) begin
			r.status = rau_pkg::ST_OVF;
			return r;
		end
		r.res_num = neg ? -num[31:0] : num[31:0];
		r.res_den = den[30:0];
		return r;
	endfunction

	function automatic frac_res_t rational_eval(frac_op_t it);
		frac_res_t   r;
		logic [63:0] an, ad, bn, bd, p, q, rn, rd;
		logic        aneg, bneg, qneg, rneg, norm, lt, eq;
		r = '{res_num: '0, res_den: '0, truth: 1'b0, status: rau_pkg::ST_OK};
		an = magnitude(it.a_num);
		ad = magnitude(it.a_den);
		bn = magnitude(it.b_num);
		bd = magnitude(it.b_den);
		aneg = (an != 0) && (it.a_num[31] != it.a_den[31]);
		bneg = (bn != 0) && (it.b_num[31] != it.b_den[31]);
		norm = it.normalize_only || it.op > rau_pkg::OP_EQ;
		if (ad == 0 || (!norm && bd == 0)) begin
			r.status = rau_pkg::ST_ZERO;
			return r;
		end
		if (norm)
			return reduce_frac(aneg, an, ad);
		case (it.op)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				p = an * bd;
				q = bn * ad;
				qneg = (it.op == rau_pkg::OP_SUB) ? !bneg : bneg;
				if (q == 0)
					qneg = 1'b0;
				rd = ad * bd;
				if (aneg == qneg) begin
					rn = p + q;
					rneg = aneg;
				end else if (p >= q) begin
					rn = p - q;
					rneg = aneg;
				end else begin
					rn = q - p;
					rneg = qneg;
				end
			end
			rau_pkg::OP_MUL: begin
				rn = an * bn;
				rd = ad * bd;
				rneg = aneg != bneg;
			end
			rau_pkg::OP_DIV: begin
				if (bn == 0) begin
					r.status = rau_pkg::ST_ZERO;
					return r;
				end
				rn = an * bd;
				rd = ad * bn;
				rneg = aneg != bneg;
			end
			default: begin
				p = an * bd;
				q = bn * ad;
				if (aneg != bneg && !(p == 0 && q == 0))
					lt = (p == 0) ? bneg == 1'b0 ? 1'b0 : 1'b0 : aneg;
				if (p == 0 && q == 0) begin
					lt = 1'b0;
					eq = 1'b1;
				end else if (p == 0) begin
					lt = !bneg;
					eq = 1'b0;
				end else if (q == 0) begin
					lt = aneg;
					eq = 1'b0;
				end else if (aneg != bneg) begin
					lt = aneg;
					eq = 1'b0;
				end else begin
					eq = p == q;
					lt = aneg ? p > q : p < q;
				end
				r.truth = (it.op == rau_pkg::OP_LT) ? lt : eq;
				return r;
			end
		endcase
		if (rn == 0)
			rneg = 1'b0;
		return reduce_frac(rneg, rn, rd);
	endfunction

	function automatic logic [31:0] pick_value(bit is_den);
		int unsigned sel;
		logic [31:0] v;
		sel = $urandom_range(99);
		if (is_den && sel < 5)
			return '0;
		if (sel < 70) begin
			v = $urandom_range(is_den ? 1 : 0, 40);
			return $urandom_range(1) ? -v : v;
		end
		if (sel < 85)
			return $urandom;
		case ($urandom_range(3))
			0: return MAX_POS;
			1: return MIN_NEG;
			2: return 32'hffff_ffff;
			default: return 32'd1;
		endcase
	endfunction

	task automatic send_beat(frac_op_t it, frac_res_t res, bit idle_ok);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, it.normalize_only, it.b_den, it.b_num, it.a_den, it.a_num, it.op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(res);
		if (idle_ok && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	table_row_t stim_table[] = '{
		'{'{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1'b0}, 1'b0,
			'{0, 0, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1'b0}, 1'b1,
			'{0, 1, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_MUL, -32'sd3, 32'd4, 32'd2, 32'd3, 1'b0}, 1'b0,
			'{0, 0, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 1'b0}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_ZERO}},
		'{'{rau_pkg::OP_LT, -32'sd1, 32'd2, 32'd1, 32'd3, 1'b0}, 1'b1,
			'{0, 0, 1, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_LT, 32'd1, 32'd3, 32'd1, 32'd3, 1'b0}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_EQ, 32'd2, 32'd4, 32'd1, 32'd2, 1'b0}, 1'b1,
			'{0, 0, 1, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_EQ, 32'd0, 32'd3, 32'd0, -32'sd5, 1'b0}, 1'b1,
			'{0, 0, 1, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_ADD, 32'd6, -32'sd4, 32'd0, 32'd0, 1'b1}, 1'b1,
			'{-32'sd3, 2, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1'b0}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_ZERO}},
		'{'{rau_pkg::OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0, 1'b0}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_ZERO}},
		'{'{rau_pkg::OP_MUL, 32'd5, 32'd10, 32'd3, 32'd0, 1'b1}, 1'b1,
			'{1, 2, 0, rau_pkg::ST_OK}},
		'{'{3'd6, 32'd4, 32'd8, 32'd9, 32'd0, 1'b0}, 1'b1,
			'{1, 2, 0, rau_pkg::ST_OK}},
		'{'{3'd7, -32'sd4, 32'd8, 32'd9, 32'd0, 1'b0}, 1'b1,
			'{-32'sd1, 2, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_ADD, MIN_NEG, 32'd1, 32'd0, 32'd0, 1'b1}, 1'b1,
			'{MIN_NEG, 1, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_ADD, 32'd1, MIN_NEG, 32'd0, 32'd0, 1'b1}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_OVF}},
		'{'{rau_pkg::OP_ADD, 32'd0, -32'sd7, 32'd0, 32'd0, 1'b1}, 1'b1,
			'{0, 1, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_MUL, MAX_POS, 32'd1, MAX_POS, 32'd1, 1'b0}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_OVF}},
		'{'{rau_pkg::OP_ADD, MAX_POS, 32'd1, MAX_POS, 32'd1, 1'b0}, 1'b1,
			'{0, 0, 0, rau_pkg::ST_OVF}},
		'{'{rau_pkg::OP_SUB, MIN_NEG, 32'd1, 32'd1, 32'd1, 1'b0}, 1'b0,
			'{0, 0, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_DIV, MIN_NEG, 32'd3, -32'sd1, 32'd7, 1'b0}, 1'b0,
			'{0, 0, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_DIV, MAX_POS, MAX_POS, MIN_NEG, MIN_NEG, 1'b0}, 1'b0,
			'{0, 0, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_ADD, MAX_POS, MAX_POS, 32'd0, 32'd0, 1'b1}, 1'b1,
			'{1, 1, 0, rau_pkg::ST_OK}},
		'{'{rau_pkg::OP_SUB, 32'hffff_ffff, 32'hffff_ffff, MIN_NEG, MAX_POS, 1'b0}, 1'b0,
			'{0, 0, 0, rau_pkg::ST_OK}}
	};

	initial begin
		frac_op_t it;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_table[i])
			send_beat(stim_table[i].stim,
				stim_table[i].typed ? stim_table[i].res : rational_eval(stim_table[i].stim), 1'b1);
		for (int n = 0; n < N_RANDOM; n++) begin
			it.op = 3'($urandom_range(7));
			it.a_num = pick_value(1'b0);
			it.a_den = pick_value(1'b1);
			it.b_num = pick_value(1'b0);
			it.b_den = pick_value(1'b1);
			it.normalize_only = $urandom_range(9) == 0;
			send_beat(it, rational_eval(it), n < 150 || n > 300);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// result monitor and backpressure; one long hold-off to stall the input side
	initial begin
		frac_res_t exp_res;
		int        hold_cycles;
		bit        held = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					exp_res = pending_results.pop_front();
					if (m_tdata[31:0] !== exp_res.res_num) begin
						$error("res_num expected %h actual %h", exp_res.res_num, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[62:32] !== exp_res.res_den) begin
						$error("res_den expected %h actual %h", exp_res.res_den, m_tdata[62:32]);
						fail_count++;
					end
					if (m_tdata[63] !== exp_res.truth) begin
						$error("truth expected %b actual %b", exp_res.truth, m_tdata[63]);
						fail_count++;
					end
					if (m_tdata[65:64] !== exp_res.status) begin
						$error("status expected %0d actual %0d", exp_res.status, m_tdata[65:64]);
						fail_count++;
					end
				end
			end
			if (!held && results_seen == 100)
				hold_cycles = 600;
			if (hold_cycles > 0) begin
				held = 1'b1;
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (results_seen >= 175 && results_seen < 325) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= $urandom_range(99) >= 36;
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (400)
			@(posedge clk);
		if (fail_count == 0)
			$display("rational_arithmetic_unit test passed");
		else
			$display("rational_arithmetic_unit test failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
design/rau_pkg.sv
design/rau_ctrl.sv
design/rau_dp.sv
design/rational_arithmetic_unit.sv
design/rau_checker.sv
test/rational_arithmetic_unit_tb.sv
